[src/bitmap_block_allocator_macros.svh]
// assertion macros shared by the allocator rtl
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bba_pkg.sv]
// shared types and constants of the bitmap block allocator
package bba_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam int unsigned OPC_W  = 1;
  localparam int unsigned RUN_W  = 4;
  localparam int unsigned BLK_W  = 11;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FC_W   = 12;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned CIDX_W = 1;

  localparam logic [CFG_W-1:0] RESERVED_RST = 12'd10;
  localparam logic [CFG_W-1:0] TOTAL_RST    = 12'd2048;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_RESERVED = 1'b0,
    REG_TOTAL    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_GR_RD,
    ST_GR_EV,
    ST_FR_RD,
    ST_FR_EV,
    ST_EMIT
  } state_e;

  // free bits of one map word that fall inside the usable range
  typedef struct packed {
    logic             any;
    logic [BIT_W:0]   count;
    logic [BIT_W-1:0] first;
  } scan_t;

endpackage

[src/bba_ram.sv]
// generic single-write, single-read ram with registered read data
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bba_scan.sv]
// masks one map word to the usable range, counts its free bits, finds the lowest
module bba_scan #(
  parameter int unsigned XW = 13
) (
  input  logic [bba_pkg::WORD_W-1:0] word_i,
  input  logic [XW-1:0]              base_i,
  input  logic [XW-1:0]              lo_i,
  input  logic [XW-1:0]              hi_i,
  output bba_pkg::scan_t             scan_o
);

  logic [bba_pkg::WORD_W-1:0] avail;

  always_comb begin
    for (int j = 0; j < bba_pkg::WORD_W; j++) begin
      avail[j] = !word_i[j] && ((base_i + XW'(j)) >= lo_i) && ((base_i + XW'(j)) < hi_i);
    end
  end

  always_comb begin
    scan_o.any   = |avail;
    scan_o.count = (bba_pkg::BIT_W + 1)'($countones(avail));
    scan_o.first = '0;
    // lowest set bit wins
    for (int j = bba_pkg::WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        scan_o.first = bba_pkg::BIT_W'(j);
      end
    end
  end

endmodule

[src/bitmap_block_allocator.sv]
// first-fit bitmap block allocator, top level
// map held in a ram of 32-bit words, each word is read and then evaluated
// allocate: counting pass over words from the low bound until the run is
//   covered, then a grant walk from the low bound that rescans a word after each grant
// free: target word read, then result loaded and the next request taken; out-of-range target rejected
// reset: map cleared one word per cycle before requests are taken
module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 2048,
  parameter int unsigned MAX_RUN    = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bba_pkg::OPC_W-1:0]     opcode_i,
  input  logic [bba_pkg::RUN_W-1:0]     run_length_i,
  input  logic [bba_pkg::BLK_W-1:0]     target_block_i,

  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bba_pkg::STAT_W-1:0]    status_o,
  output logic [bba_pkg::BLK_W-1:0]     granted_block_o,
  output logic [bba_pkg::FC_W-1:0]      free_count_o,
  output logic                          last_o,

  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data_i
);

`include "bitmap_block_allocator_macros.svh"

  localparam int unsigned WORD_W    = bba_pkg::WORD_W;
  localparam int unsigned BIT_W     = bba_pkg::BIT_W;
  localparam int unsigned NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  // used-count width, holds NUM_BLOCKS itself
  localparam int unsigned BW        = $clog2(NUM_BLOCKS + 1);
  // width of range bounds, wide enough for the config registers too
  localparam int unsigned LW        = (BW > bba_pkg::CFG_W) ? BW : bba_pkg::CFG_W;
  // bit positions, one past the last word included
  localparam int unsigned XW        = LW + 1;
  // run counter during the counting pass
  localparam int unsigned CNTW      = $clog2(MAX_RUN + WORD_W + 1);

  // ------------------------------------------------------------------
  // configuration registers, always writable
  // ------------------------------------------------------------------
  logic [bba_pkg::CFG_W-1:0] reserved_q, reserved_d;
  logic [bba_pkg::CFG_W-1:0] total_q, total_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    reserved_d = reserved_q;
    total_d    = total_q;
    if (cfg_valid_i) begin
      unique case (bba_pkg::cfg_reg_e'(cfg_index_i))
        bba_pkg::REG_RESERVED: reserved_d = cfg_data_i;
        bba_pkg::REG_TOTAL:    total_d    = cfg_data_i;
        default:               reserved_d = reserved_q;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // usable range [lo, hi) and free block counts
  // ------------------------------------------------------------------
  logic [LW-1:0] total_x, reserved_x, hi, lo, usable;
  logic [BW-1:0] used_count_q, used_count_d;
  logic [LW-1:0] free_now, free_inc, free_dec;
  logic [BW-1:0] used_dec;

  function automatic logic [LW-1:0] sat_sub(input logic [LW-1:0] a, input logic [LW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  assign total_x    = LW'(total_q);
  assign reserved_x = LW'(reserved_q);
  assign hi         = (total_x < LW'(NUM_BLOCKS)) ? total_x : LW'(NUM_BLOCKS);
  assign lo         = (reserved_x < hi) ? reserved_x : hi;
  assign usable     = hi - lo;
  assign used_dec   = (used_count_q != '0) ? used_count_q - BW'(1) : used_count_q;
  assign free_now   = sat_sub(usable, LW'(used_count_q));
  assign free_inc   = sat_sub(usable, LW'(used_count_q) + LW'(1));
  assign free_dec   = sat_sub(usable, LW'(used_dec));

  logic [AW-1:0] lo_word, hi_word;
  assign lo_word = AW'(lo >> BIT_W);
  assign hi_word = AW'((hi - LW'(1)) >> BIT_W);

  // ------------------------------------------------------------------
  // map memory and word scanner
  // ------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]     addr_q, addr_d;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  logic [XW-1:0]  word_base;
  bba_pkg::scan_t scan;

  assign word_base = XW'(addr_q) << BIT_W;

  bba_scan #(
    .XW (XW)
  ) u_scan (
    .word_i (ram_rdata),
    .base_i (word_base),
    .lo_i   (XW'(lo)),
    .hi_i   (XW'(hi)),
    .scan_o (scan)
  );

  // ------------------------------------------------------------------
  // sequencer state and item registers
  // ------------------------------------------------------------------
  bba_pkg::state_e state_q, state_d;
  logic [CNTW-1:0]            cnt_q, cnt_d;
  logic [bba_pkg::RUN_W-1:0]  granted_q, granted_d;
  logic [bba_pkg::RUN_W-1:0]  run_q, run_d;
  logic [bba_pkg::BLK_W-1:0]  target_q, target_d;
  logic [bba_pkg::STAT_W-1:0] pend_status_q, pend_status_d;
  logic [bba_pkg::BLK_W-1:0]  pend_block_q, pend_block_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [bba_pkg::STAT_W-1:0] status_q, status_d;
  logic [bba_pkg::BLK_W-1:0]  block_q, block_d;
  logic [bba_pkg::FC_W-1:0]   free_q, free_d;
  logic                       last_q, last_d;
  logic                       out_load;

  logic                  in_fire, slot_free;
  logic                  bad_run, short_run, tgt_out;
  logic [LW-1:0]         tgt_x;
  logic [CNTW-1:0]       cnt_sum;
  logic                  grant_last, map_bit;
  logic [WORD_W-1:0]     first_mask, target_mask;

  assign in_ready_o = (state_q == bba_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // request checks decided at accept
  assign bad_run    = (run_length_i == '0) || (32'(run_length_i) > MAX_RUN);
  assign short_run  = LW'(run_length_i) > free_now;
  assign tgt_x      = LW'(target_block_i);
  assign tgt_out    = (tgt_x < lo) || (tgt_x >= hi);

  assign cnt_sum     = cnt_q + CNTW'(scan.count);
  assign grant_last  = (granted_q + bba_pkg::RUN_W'(1)) == run_q;
  assign first_mask  = WORD_W'(1) << scan.first;
  assign target_mask = WORD_W'(1) << target_q[BIT_W-1:0];
  assign map_bit     = |(ram_rdata & target_mask);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::ST_CLEAR: begin
        if (addr_q == AW'(NUM_WORDS - 1)) state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (bba_pkg::op_e'(opcode_i) == bba_pkg::OP_FREE) begin
            state_d = tgt_out ? bba_pkg::ST_EMIT : bba_pkg::ST_FR_RD;
          end else if (bad_run || short_run) begin
            state_d = bba_pkg::ST_EMIT;
          end else begin
            state_d = bba_pkg::ST_CHK_RD;
          end
        end
      end
      bba_pkg::ST_CHK_RD: state_d = bba_pkg::ST_CHK_EV;
      bba_pkg::ST_CHK_EV: begin
        priority if (cnt_sum >= CNTW'(run_q)) state_d = bba_pkg::ST_GR_RD;
        else if (addr_q == hi_word)           state_d = bba_pkg::ST_EMIT;
        else                                  state_d = bba_pkg::ST_CHK_RD;
      end
      bba_pkg::ST_GR_RD: state_d = bba_pkg::ST_GR_EV;
      bba_pkg::ST_GR_EV: begin
        priority if (!scan.any) state_d = bba_pkg::ST_GR_RD;
        else if (slot_free)     state_d = grant_last ? bba_pkg::ST_IDLE : bba_pkg::ST_GR_RD;
        else                    state_d = bba_pkg::ST_GR_EV;
      end
      bba_pkg::ST_FR_RD: state_d = bba_pkg::ST_FR_EV;
      bba_pkg::ST_FR_EV: begin
        if (slot_free) state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_EMIT: begin
        if (slot_free) state_d = bba_pkg::ST_IDLE;
      end
      default: state_d = bba_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = ram_rdata;
    addr_d        = addr_q;
    cnt_d         = cnt_q;
    granted_d     = granted_q;
    run_d         = run_q;
    target_d      = target_q;
    pend_status_d = pend_status_q;
    pend_block_d  = pend_block_q;
    used_count_d  = used_count_q;
    out_load      = 1'b0;
    status_d      = status_q;
    block_d       = block_q;
    free_d        = free_q;
    last_d        = last_q;

    unique case (state_q)
      bba_pkg::ST_CLEAR: begin
        // zero one map word per cycle
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_d    = addr_q + AW'(1);
      end
      bba_pkg::ST_IDLE: begin
        if (in_fire) begin
          run_d         = run_length_i;
          target_d      = target_block_i;
          cnt_d         = '0;
          granted_d     = '0;
          addr_d        = lo_word;
          pend_block_d  = '0;
          pend_status_d = bba_pkg::STAT_NO_SPACE;
          priority if (bba_pkg::op_e'(opcode_i) == bba_pkg::OP_FREE) begin
            pend_status_d = bba_pkg::STAT_BAD_INDEX;
            pend_block_d  = target_block_i;
            addr_d        = AW'(target_block_i >> BIT_W);
          end else if (bad_run) begin
            pend_status_d = bba_pkg::STAT_BAD_INDEX;
          end else begin
            pend_status_d = bba_pkg::STAT_NO_SPACE;
          end
        end
      end
      bba_pkg::ST_CHK_RD, bba_pkg::ST_GR_RD, bba_pkg::ST_FR_RD: begin
        ram_re = 1'b1;
      end
      bba_pkg::ST_CHK_EV: begin
        // count free blocks until the run is covered or the range ends
        cnt_d = cnt_sum;
        priority if (cnt_sum >= CNTW'(run_q)) addr_d = lo_word;
        else if (addr_q == hi_word)           addr_d = addr_q;
        else                                  addr_d = addr_q + AW'(1);
      end
      bba_pkg::ST_GR_EV: begin
        priority if (!scan.any) begin
          addr_d = addr_q + AW'(1);
        end else if (slot_free) begin
          // mark the lowest free block, the same word is rescanned next
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata | first_mask;
          used_count_d = used_count_q + BW'(1);
          granted_d    = granted_q + bba_pkg::RUN_W'(1);
          out_load     = 1'b1;
          status_d     = bba_pkg::STAT_OK;
          block_d      = bba_pkg::BLK_W'(word_base + XW'(scan.first));
          free_d       = bba_pkg::FC_W'(free_inc);
          last_d       = grant_last;
        end else begin
          addr_d = addr_q;
        end
      end
      bba_pkg::ST_FR_EV: begin
        if (slot_free) begin
          out_load = 1'b1;
          block_d  = target_q;
          last_d   = 1'b1;
          if (map_bit) begin
            ram_we       = 1'b1;
            ram_wdata    = ram_rdata & ~target_mask;
            used_count_d = used_dec;
            status_d     = bba_pkg::STAT_OK;
            free_d       = bba_pkg::FC_W'(free_dec);
          end else begin
            status_d = bba_pkg::STAT_NOT_ALLOC;
            free_d   = bba_pkg::FC_W'(free_now);
          end
        end
      end
      bba_pkg::ST_EMIT: begin
        // single rejected result, state untouched
        if (slot_free) begin
          out_load = 1'b1;
          status_d = pend_status_q;
          block_d  = pend_block_q;
          free_d   = bba_pkg::FC_W'(free_now);
          last_d   = 1'b1;
        end
      end
      default: begin
        addr_d = addr_q;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bba_pkg::ST_CLEAR;
      addr_q       <= '0;
      cnt_q        <= '0;
      granted_q    <= '0;
      used_count_q <= '0;
      reserved_q   <= bba_pkg::RESERVED_RST;
      total_q      <= bba_pkg::TOTAL_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      cnt_q        <= cnt_d;
      granted_q    <= granted_d;
      used_count_q <= used_count_d;
      reserved_q   <= reserved_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    run_q         <= run_d;
    target_q      <= target_d;
    pend_status_q <= pend_status_d;
    pend_block_q  <= pend_block_d;
    status_q      <= status_d;
    block_q       <= block_d;
    free_q        <= free_d;
    last_q        <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = block_q;
  assign free_count_o    = free_q;
  assign last_o          = last_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `BBA_ASSERT_NOW(a_count_bound, 1'b1, used_count_q <= BW'(NUM_BLOCKS), "used count overflow")
  `BBA_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_q || out_ready_i, "result overwritten")
  `BBA_ASSERT_NEXT(a_grant_counts,
                   (state_q == bba_pkg::ST_GR_EV) && out_load,
                   used_count_q == $past(used_count_q) + BW'(1),
                   "grant not counted")

endmodule
